>>> rtl/core/wss_pkg.sv
package wss_pkg;

    // Block dimensions
    localparam int WINDOW   = 64;
    localparam int CHANNELS = 5;

    // Fixed field widths
    localparam int VAL_W     = 24;
    localparam int CH_W      = 3;
    localparam int CNT_OUT_W = 7;
    localparam int SUM_OUT_W = 30;

    // Derived widths
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int DIV_W  = $clog2(SUM_W);
    localparam int WORD_W = VAL_W + 1;

    // Command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Sequencer steps
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_WR,
        S_RD,
        S_ACC,
        S_DIVI,
        S_DIV,
        S_OUT
    } t_step;

    // Branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_GO,
        C_CLR_LAST,
        C_K_LAST,
        C_DIV_LAST,
        C_OUT_FREE
    } t_cond;

    // Datapath controls, one or more per step
    typedef struct packed {
        logic idle;
        logic clr_wr;
        logic smp_wr;
        logic acc_init;
        logic rd_issue;
        logic acc_en;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_ctrl;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic go;
        logic clr_last;
        logic k_last;
        logic div_last;
        logic out_free;
    } t_stat;

    // One control word
    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_ucode;

    // Control store
    function automatic t_ucode ucode_rom(input t_step s);
        t_ucode u;
        u       = '0;
        u.cond  = C_ALWAYS;
        u.tgt_t = S_IDLE;
        u.tgt_f = S_IDLE;
        unique case (s)
            S_CLR: begin
                u.ctrl.clr_wr = 1'b1;
                u.cond        = C_CLR_LAST;
                u.tgt_t       = S_IDLE;
                u.tgt_f       = S_CLR;
            end
            S_IDLE: begin
                u.ctrl.idle = 1'b1;
                u.cond      = C_GO;
                u.tgt_t     = S_WR;
                u.tgt_f     = S_IDLE;
            end
            S_WR: begin
                u.ctrl.smp_wr   = 1'b1;
                u.ctrl.acc_init = 1'b1;
                u.tgt_t         = S_RD;
            end
            S_RD: begin
                u.ctrl.rd_issue = 1'b1;
                u.tgt_t         = S_ACC;
            end
            S_ACC: begin
                u.ctrl.acc_en = 1'b1;
                u.cond        = C_K_LAST;
                u.tgt_t       = S_DIVI;
                u.tgt_f       = S_RD;
            end
            S_DIVI: begin
                u.ctrl.div_init = 1'b1;
                u.tgt_t         = S_DIV;
            end
            S_DIV: begin
                u.ctrl.div_step = 1'b1;
                u.cond          = C_DIV_LAST;
                u.tgt_t         = S_OUT;
                u.tgt_f         = S_DIV;
            end
            S_OUT: begin
                u.ctrl.out_load = 1'b1;
                u.cond          = C_OUT_FREE;
                u.tgt_t         = S_IDLE;
                u.tgt_f         = S_OUT;
            end
        endcase
        return u;
    endfunction

endpackage

>>> rtl/core/wss_ram.sv
module wss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/wss_dpath.sv
module wss_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wss_pkg::t_ctrl            i_ctrl,
    output wss_pkg::t_stat            o_stat,
    input  logic                      i_in_valid,
    input  logic                      i_command,
    input  logic [2:0]                i_channel,
    input  logic [23:0]               i_sample_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_channel_out,
    output logic [6:0]                o_valid_count,
    output logic [29:0]               o_window_sum,
    output logic [23:0]               o_window_min,
    output logic [23:0]               o_window_max,
    output logic [23:0]               o_window_mean
);

    import wss_pkg::*;

    logic              in_acc;
    logic              ch_ok;
    logic [ADDR_W-1:0] base;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              rd_vld;
    logic [VAL_W-1:0]  rd_val;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              q_bit;
    logic              out_free;

    logic [ADDR_W-1:0] r_clr;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_k;
    logic [CH_W-1:0]   r_ch;
    logic [VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [VAL_W-1:0]  r_min;
    logic [VAL_W-1:0]  r_max;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dstep;
    logic              r_out_valid;
    logic [CH_W-1:0]   r_o_ch;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [SUM_W-1:0]  r_o_sum;
    logic [VAL_W-1:0]  r_o_min;
    logic [VAL_W-1:0]  r_o_max;
    logic [VAL_W-1:0]  r_o_mean;

    // Input word decode
    assign in_acc = i_in_valid & i_ctrl.idle;
    assign ch_ok  = (32'(i_channel) < CHANNELS);

    // Channel row base and RAM addressing
    assign base    = ADDR_W'(r_ch) * ADDR_W'(WINDOW);
    assign wr_en   = i_ctrl.clr_wr | i_ctrl.smp_wr;
    assign wr_addr = i_ctrl.clr_wr ? r_clr : (base + ADDR_W'(r_slot));
    assign wr_data = i_ctrl.clr_wr ? '0 : {1'b1, r_val};
    assign rd_addr = base + ADDR_W'(r_k);

    wss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_ctrl.rd_issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_vld = rd_data[WORD_W-1];
    assign rd_val = rd_data[VAL_W-1:0];

    // Restoring divide, one quotient bit a step
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_cnt};
    assign q_bit = (trial >= {1'b0, r_cnt});

    assign out_free = ~r_out_valid | ~i_out_stall;

    // Status to sequencer
    always_comb begin
        o_stat.go       = in_acc & (i_command == CMD_SAMPLE) & ch_ok;
        o_stat.clr_last = (r_clr == ADDR_W'(DEPTH - 1));
        o_stat.k_last   = (r_k == SLOT_W'(WINDOW - 1));
        o_stat.div_last = (r_dstep == DIV_W'(SUM_W - 1));
        o_stat.out_free = out_free;
    end

    // Control registers: clear pointer, frame slot, result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_acc && (i_command == CMD_TICK)) begin
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_ctrl.out_load && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Accumulators, cleared at reset so the checks below see known values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (i_ctrl.acc_init) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (i_ctrl.acc_en && rd_vld) begin
            r_cnt <= r_cnt + 1'b1;
            r_sum <= r_sum + SUM_W'(rd_val);
            if (rd_val < r_min) begin
                r_min <= rd_val;
            end
            if (rd_val > r_max) begin
                r_max <= rd_val;
            end
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo   <= '0;
            r_rem   <= '0;
            r_dstep <= '0;
        end else if (i_ctrl.div_init) begin
            r_quo   <= r_sum;
            r_rem   <= '0;
            r_dstep <= '0;
        end else if (i_ctrl.div_step) begin
            r_quo   <= {r_quo[SUM_W-2:0], q_bit};
            r_rem   <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_dstep <= r_dstep + 1'b1;
        end
    end

    // Sample latch and scan index
    always_ff @(posedge i_clk) begin
        if (o_stat.go) begin
            r_ch  <= i_channel;
            r_val <= i_sample_value;
        end
        if (i_ctrl.acc_init) begin
            r_k <= '0;
        end else if (i_ctrl.acc_en) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load && out_free) begin
            r_o_ch   <= r_ch;
            r_o_cnt  <= r_cnt;
            r_o_sum  <= r_sum;
            r_o_min  <= r_min;
            r_o_max  <= r_max;
            r_o_mean <= r_quo[VAL_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_o_ch;
    assign o_valid_count = CNT_OUT_W'(r_o_cnt);
    assign o_window_sum  = SUM_OUT_W'(r_o_sum);
    assign o_window_min  = r_o_min;
    assign o_window_max  = r_o_max;
    assign o_window_mean = r_o_mean;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW))
        else $error("valid count beyond window");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_step |-> (r_rem < r_cnt))
        else $error("divider remainder not below divisor");

    a_mean_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_load |-> (r_quo <= SUM_W'(r_max)))
        else $error("mean exceeds window maximum");

endmodule

>>> rtl/core/wss_useq.sv
module wss_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wss_pkg::t_stat i_stat,
    output wss_pkg::t_ctrl o_ctrl
);

    import wss_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_ucode uword;
    logic   cond_true;

    assign uword = ucode_rom(r_step);

    // Branch condition select
    always_comb begin
        unique case (uword.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_GO:       cond_true = i_stat.go;
            C_CLR_LAST: cond_true = i_stat.clr_last;
            C_K_LAST:   cond_true = i_stat.k_last;
            C_DIV_LAST: cond_true = i_stat.div_last;
            C_OUT_FREE: cond_true = i_stat.out_free;
            default:    cond_true = 1'b1;
        endcase
    end

    // Next step
    always_comb begin
        n_step = cond_true ? uword.tgt_t : uword.tgt_f;
    end

    // Control outputs
    always_comb begin
        o_ctrl = uword.ctrl;
    end

    // Step counter, clearing pass first after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_OUT && i_stat.out_free) |=> (r_step == S_IDLE))
        else $error("sequencer did not return to idle after result");

endmodule

>>> rtl/core/windowed_sample_statistics_top.sv
// Windowed sample statistics: per channel, a ring of WINDOW samples indexed by
// a shared frame slot. A tick word (command 0) advances the slot and gives no
// result; a sample word (command 1) for a channel below CHANNELS stores the
// value in that channel's current slot and returns count, sum, min, max and
// truncated mean over the channel's valid slots. Words for other channels are
// taken and dropped. After reset the block holds off input while it clears
// the valid flags in all DEPTH (CHANNELS*WINDOW, 320 here) words of the store.
// A tick is taken without leaving the idle step. A sample is worked as one
// write, then a read and an accumulate step per window slot through the single
// read port of the sample RAM, then a divide that gives one quotient bit per
// cycle, all stepped by a microcoded sequencer. One word is worked at a time;
// a result waiting in the output register holds the sequencer until it is
// taken, but input is accepted again as soon as the result is loaded.
module windowed_sample_statistics_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [2:0]  i_channel,
    input  logic [23:0] i_sample_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_channel_out,
    output logic [6:0]  o_valid_count,
    output logic [29:0] o_window_sum,
    output logic [23:0] o_window_min,
    output logic [23:0] o_window_max,
    output logic [23:0] o_window_mean
);

    import wss_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    assign o_in_stall = ~ctrl.idle;

    wss_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    wss_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_in_valid     (i_in_valid),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel_out  (o_channel_out),
        .o_valid_count  (o_valid_count),
        .o_window_sum   (o_window_sum),
        .o_window_min   (o_window_min),
        .o_window_max   (o_window_max),
        .o_window_mean  (o_window_mean)
    );

endmodule
